// ----- sv/biq_pkg.sv -----
package biq_pkg;

  // Coefficient and shift register widths are fixed by the register map.
  localparam int COEF_WIDTH      = 16;
  localparam int SHIFT_WIDTH     = 4;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // Register map.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NB1   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NB2   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_A0    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE = 3'd5;

  // Reset values.
  localparam logic signed [COEF_WIDTH-1:0] RST_NB1   = 16'sd0;
  localparam logic signed [COEF_WIDTH-1:0] RST_NB2   = 16'sd0;
  localparam logic signed [COEF_WIDTH-1:0] RST_A0    = 16'sd16384;
  localparam logic signed [COEF_WIDTH-1:0] RST_A1    = 16'sd0;
  localparam logic signed [COEF_WIDTH-1:0] RST_A2    = 16'sd0;
  localparam logic [SHIFT_WIDTH-1:0]       RST_SCALE = 4'd14;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NB1_ZN,
    MUL_NB2_ZO,
    MUL_A0_M,
    MUL_A1_ZN,
    MUL_A2_ZO
  } mul_sel_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     load;     // capture request, scale delay words, seed accumulator
    logic     mul_en;   // register a product
    mul_sel_t mul_sel;
    logic     acc_add;  // accumulate the registered product
    logic     commit;   // shift delay line, clear accumulator
    logic     out_load; // saturate and register the result
  } dp_cmd_t;

endpackage

// ----- sv/biq_in_if.sv -----
interface biq_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- sv/biq_out_if.sv -----
interface biq_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- sv/biq_ctrl.sv -----
module biq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output biq_pkg::dp_cmd_t cmd
);
  import biq_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    FB1,
    FB2,
    FB3,
    FF0,
    FF1,
    FF2,
    FF3,
    SAT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '{load: 1'b0, mul_en: 1'b0, mul_sel: MUL_NB1_ZN,
            acc_add: 1'b0, commit: 1'b0, out_load: 1'b0};
    unique case (state)
      IDLE: cmd.load = in_valid;
      FB1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NB1_ZN;
      end
      FB2: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NB2_ZO;
      end
      FB3: cmd.acc_add = 1'b1;
      FF0: begin
        cmd.commit  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A0_M;
      end
      FF1: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A1_ZN;
      end
      FF2: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A2_ZO;
      end
      FF3: cmd.acc_add = 1'b1;
      SAT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == SAT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: if (in_valid) begin
          state <= FB1;
        end
        FB1: state <= FB2;
        FB2: state <= FB3;
        FB3: state <= FF0;
        FF0: state <= FF1;
        FF1: state <= FF2;
        FF2: state <= FF3;
        FF3: state <= SAT;
        SAT: if (out_free) begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- sv/biq_datapath.sv -----
module biq_datapath #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [biq_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [biq_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  biq_pkg::dp_cmd_t                     cmd,
  input  logic signed [DATA_WIDTH-1:0]         sample_in,
  output logic signed [DATA_WIDTH-1:0]         sample_out
);
  import biq_pkg::*;

  localparam int PROD_WIDTH = ACC_WIDTH + COEF_WIDTH;
  localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
    ACC_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

  logic signed [COEF_WIDTH-1:0]  coef_nb1, coef_nb2, coef_a0, coef_a1, coef_a2;
  logic [SHIFT_WIDTH-1:0]        scale_shift;

  logic signed [ACC_WIDTH-1:0]   delay_newest, delay_older;
  logic signed [ACC_WIDTH-1:0]   zn, zo, acc, prod;

  logic signed [ACC_WIDTH-1:0]   x_ext;
  logic signed [COEF_WIDTH-1:0]  mul_coef;
  logic signed [ACC_WIDTH-1:0]   mul_opnd;
  logic signed [PROD_WIDTH-1:0]  mul_full;
  logic signed [ACC_WIDTH-1:0]   y_shift;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_nb1    <= RST_NB1;
      coef_nb2    <= RST_NB2;
      coef_a0     <= RST_A0;
      coef_a1     <= RST_A1;
      coef_a2     <= RST_A2;
      scale_shift <= RST_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NB1:   coef_nb1    <= cfg_data;
        REG_NB2:   coef_nb2    <= cfg_data;
        REG_A0:    coef_a0     <= cfg_data;
        REG_A1:    coef_a1     <= cfg_data;
        REG_A2:    coef_a2     <= cfg_data;
        REG_SCALE: scale_shift <= cfg_data[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign x_ext = ACC_WIDTH'(sample_in);

  // Shared multiplier operand select; only the low ACC_WIDTH bits are kept.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_NB1_ZN: begin mul_coef = coef_nb1; mul_opnd = zn;                  end
      MUL_NB2_ZO: begin mul_coef = coef_nb2; mul_opnd = zo;                  end
      MUL_A0_M:   begin mul_coef = coef_a0;  mul_opnd = acc >>> scale_shift; end
      MUL_A1_ZN:  begin mul_coef = coef_a1;  mul_opnd = zn;                  end
      MUL_A2_ZO:  begin mul_coef = coef_a2;  mul_opnd = zo;                  end
      default:    begin mul_coef = coef_a2;  mul_opnd = zo;                  end
    endcase
  end

  assign mul_full = PROD_WIDTH'(mul_coef) * PROD_WIDTH'(mul_opnd);
  assign y_shift  = acc >>> scale_shift;

  // Delay line.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_newest <= '0;
      delay_older  <= '0;
    end else if (cmd.commit) begin
      delay_newest <= acc;
      delay_older  <= delay_newest;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zn  <= delay_newest >>> scale_shift;
      zo  <= delay_older >>> scale_shift;
      acc <= x_ext <<< scale_shift;
    end else if (cmd.commit) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
    if (cmd.mul_en) begin
      prod <= mul_full[ACC_WIDTH-1:0];
    end
    if (cmd.out_load) begin
      priority if (y_shift > SAT_HI) begin
        sample_out <= SAT_HI[DATA_WIDTH-1:0];
      end else if (y_shift < SAT_LO) begin
        sample_out <= SAT_LO[DATA_WIDTH-1:0];
      end else begin
        sample_out <= y_shift[DATA_WIDTH-1:0];
      end
    end
  end

endmodule

// ----- sv/biquad_iir_filter_core.sv -----
// Second-order IIR section, direct form II, fixed point. Each request on din
// carries one signed sample; one saturated filtered sample leaves on dout per
// request. Coefficients are written through the cfg port (index 0 nb1, 1 nb2,
// 2 a0, 3 a1, 4 a2, 5 scale_shift; other indexes ignored); the user must
// write them only while the block is idle, which the block does not enforce.
// The feedback coefficients are stored negated. A request runs a load step,
// five products one at a time through a single shared 16 x ACC_WIDTH
// multiplier, each registered and accumulated on the following cycle, and a
// saturate step into the result register. din is ready again the cycle after
// the result is registered, even if dout has not yet taken the previous
// result; no new sample is taken before that. Delay words, feedback value and
// output sum wrap at ACC_WIDTH bits, and all right shifts are arithmetic.
module biquad_iir_filter_core #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [biq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [biq_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  biq_in_if.sink                              din,
  biq_out_if.source                           dout
);
  import biq_pkg::*;

  dp_cmd_t cmd;

  // Sequencer: walks the five multiply steps and owns the handshakes.
  biq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .cmd       (cmd)
  );

  // Coefficient registers, delay line, shared multiplier, accumulator and
  // the saturating result register.
  biq_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sample_in  (din.sample_in),
    .sample_out (dout.sample_out)
  );

endmodule

// ----- tb/sv/biquad_iir_filter_core_tb.sv -----
`timescale 1ns / 100ps

module biquad_iir_filter_core_tb;
  import biq_pkg::*;

  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 32;

  // Indexes past the register map; writes there must change nothing.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE7 = 3'd7;

  localparam int SETTLE_CYCLES = 16;   // settle time after the last result returns
  localparam int STALL_LIMIT   = 4000; // cycles with no request moving on either side
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_LEN     = 100;

  localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MIN = 16'sh8000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  biq_in_if  #(.DATA_WIDTH(DATA_WIDTH)) din_if ();
  biq_out_if #(.DATA_WIDTH(DATA_WIDTH)) dout_if ();

  biquad_iir_filter_core #(
    .DATA_WIDTH(DATA_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .din      (din_if),
    .dout     (dout_if)
  );

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of the coefficients, scale and delay line.
  // ---------------------------------------------------------------------------
  logic signed [COEF_WIDTH-1:0] coef_nb1, coef_nb2, coef_a0, coef_a1, coef_a2;
  logic [SHIFT_WIDTH-1:0]       scale;
  logic signed [ACC_WIDTH-1:0]  delay_newest, delay_older;

  logic signed [DATA_WIDTH-1:0] expected_samples[$];
  int mismatch_count;

  // Mirror a register write. Unused indexes drop; extra data bits are ignored.
  function automatic void apply_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                    input logic [CFG_DATA_WIDTH-1:0] value);
    case (idx)
      REG_NB1:   coef_nb1 = value;
      REG_NB2:   coef_nb2 = value;
      REG_A0:    coef_a0  = value;
      REG_A1:    coef_a1  = value;
      REG_A2:    coef_a2  = value;
      REG_SCALE: scale    = value[SHIFT_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  // One filter step: returns the saturated output and advances the delay line.
  // Note nb1 weights the newest word and nb2 the older one.
  function automatic logic signed [DATA_WIDTH-1:0] filter_predict(
      input logic signed [DATA_WIDTH-1:0] x);
    longint zn, zo, acc, fb, y;
    logic signed [ACC_WIDTH-1:0] wrapped;
    zn  = longint'(delay_newest) >>> scale;
    zo  = longint'(delay_older) >>> scale;
    acc = longint'(coef_nb1) * zn + longint'(coef_nb2) * zo + (longint'(x) <<< scale);
    wrapped = acc[ACC_WIDTH-1:0];               // feedback value wraps
    fb  = longint'(wrapped);
    acc = longint'(coef_a0) * (fb >>> scale) + longint'(coef_a1) * zn
        + longint'(coef_a2) * zo;
    wrapped = acc[ACC_WIDTH-1:0];               // output sum wraps before shift
    y   = longint'(wrapped) >>> scale;
    delay_older  = delay_newest;
    delay_newest = fb[ACC_WIDTH-1:0];
    if (y > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (y < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return y[DATA_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed stimulus table
  // ---------------------------------------------------------------------------
  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [CFG_INDEX_WIDTH-1:0]   idx;
    logic [CFG_DATA_WIDTH-1:0]    value;
    logic signed [DATA_WIDTH-1:0] sample;
    bit                           typed;   // want holds a hand-written result
    logic signed [DATA_WIDTH-1:0] want;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic void add_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                    input logic [CFG_DATA_WIDTH-1:0] value);
    stim_rows.push_back('{ROW_WRITE, idx, value, '0, 1'b0, '0});
  endfunction

  function automatic void add_sample(input logic signed [DATA_WIDTH-1:0] x);
    stim_rows.push_back('{ROW_SAMPLE, '0, '0, x, 1'b0, '0});
  endfunction

  function automatic void add_sample_exp(input logic signed [DATA_WIDTH-1:0] x,
                                         input logic signed [DATA_WIDTH-1:0] want);
    stim_rows.push_back('{ROW_SAMPLE, '0, '0, x, 1'b1, want});
  endfunction

  // ---------------------------------------------------------------------------
  // Idle shaping: percentages set per phase; mostly short gaps, a few long.
  // ---------------------------------------------------------------------------
  int tx_idle_pct;
  int rx_stall_pct;

  function automatic int pick_gap(input int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // Wild: full range with extremes. Tame: small relative to 2^scale so the
  // filter runs in its linear region and outputs are not all clipped.
  function automatic logic [CFG_DATA_WIDTH-1:0] pick_coef(input bit wild,
                                                          input logic [SHIFT_WIDTH-1:0] s);
    int span;
    if (wild) begin
      case ($urandom_range(0, 7))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        default: return 16'($urandom);
      endcase
    end
    span = (1 << s) / 2;
    if (span < 1) span = 1;
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, drivers
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input side: drive at negedge, request taken on the posedge with ready.
  // valid stays high across back-to-back requests; only the data changes.
  task automatic send_sample(input logic signed [DATA_WIDTH-1:0] x, input bit typed,
                             input logic signed [DATA_WIDTH-1:0] want);
    int gap;
    logic signed [DATA_WIDTH-1:0] pred;
    gap = pick_gap(tx_idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      din_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    din_if.valid     = 1'b1;
    din_if.sample_in = x;
    do @(posedge clk); while (!din_if.ready);
    pred = filter_predict(x);
    expected_samples.push_back(typed ? want : pred);
  endtask

  // Drop valid and hold off until every expected result is back and the
  // datapath has had time to settle. Used before writes and as back-pressure.
  task automatic wait_drained();
    @(negedge clk);
    din_if.valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    apply_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Output side ready: random stalls decided at negedge.
  initial begin
    int stall_left;
    stall_left    = 0;
    dout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        dout_if.ready = 1'b0;
        stall_left--;
      end else begin
        dout_if.ready = 1'b1;
        stall_left = pick_gap(rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: in-order compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [DATA_WIDTH-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && dout_if.valid && dout_if.ready) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result sample_out=%0d", $time, dout_if.sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (dout_if.sample_out !== want) begin
            mismatch_count++;
            $display("%0t: sample_out mismatch: expected %0d actual %0d",
                     $time, want, dout_if.sample_out);
          end
        end
      end
    end
  end

  // Watchdog: a run that stops moving requests on both sides is hung.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL biquad_iir_filter_core");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SHIFT_WIDTH-1:0] s;
    bit wild;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    din_if.valid     = 1'b0;
    din_if.sample_in = '0;
    mismatch_count   = 0;
    tx_idle_pct      = 30;
    rx_stall_pct     = 30;

    coef_nb1     = RST_NB1;
    coef_nb2     = RST_NB2;
    coef_a0      = RST_A0;
    coef_a1      = RST_A1;
    coef_a2      = RST_A2;
    scale        = RST_SCALE;
    delay_newest = '0;
    delay_older  = '0;

    // Reset defaults give unity gain: output equals input.
    add_sample_exp(SAMPLE_MAX, SAMPLE_MAX);
    add_sample_exp(SAMPLE_MIN, SAMPLE_MIN);
    add_sample_exp(16'sd0, 16'sd0);
    add_sample_exp(16'sd1, 16'sd1);
    add_sample_exp(-16'sd1, -16'sd1);
    // No scaling, a0 at max: y = 32767*x, clipped to 16 bits.
    add_write(REG_SCALE, 16'd0);
    add_write(REG_A0, 16'h7FFF);
    add_sample_exp(SAMPLE_MAX, SAMPLE_MAX);
    add_sample_exp(SAMPLE_MIN, SAMPLE_MIN);
    add_sample_exp(16'sd1, SAMPLE_MAX);
    add_sample_exp(-16'sd1, -16'sd32767);
    add_sample_exp(16'sd0, 16'sd0);
    // Output sum past 32 bits: three full-scale negative taps wrap positive.
    add_write(REG_A1, 16'h7FFF);
    add_write(REG_A2, 16'h7FFF);
    add_sample(SAMPLE_MIN);
    add_sample(SAMPLE_MIN);
    add_sample(SAMPLE_MIN);
    // Max feedback: the feedback value grows and wraps at 32 bits.
    add_write(REG_NB1, 16'h7FFF);
    add_write(REG_NB2, 16'h7FFF);
    add_sample(SAMPLE_MAX);
    add_sample(SAMPLE_MAX);
    add_sample(SAMPLE_MAX);
    add_sample(SAMPLE_MAX);
    // Largest scale with most-negative coefficients.
    add_write(REG_SCALE, 16'd15);
    add_write(REG_NB1, 16'h8000);
    add_write(REG_NB2, 16'h8000);
    add_write(REG_A0, 16'h8000);
    add_write(REG_A1, 16'h8000);
    add_write(REG_A2, 16'h8000);
    add_sample(SAMPLE_MIN);
    add_sample(SAMPLE_MAX);
    add_sample(SAMPLE_MIN);
    // Writes past the map are dropped; upper data bits of the scale ignored.
    add_write(REG_SPARE6, 16'h1234);
    add_write(REG_SPARE7, 16'hFFFF);
    add_write(REG_SCALE, 16'hFFF5);
    add_sample(16'sh5A5A);
    add_sample(-16'sh2345);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(stim_rows[i].idx, stim_rows[i].value);
      end else begin
        send_sample(stim_rows[i].sample, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases: fresh coefficients each phase, two phases pinned to the
    // scale extremes, every third phase with wild full-range coefficients.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wild = (p % 3 == 0);
      case (p)
        1:       s = 4'd0;
        2:       s = 4'd15;
        default: s = wild ? 4'($urandom_range(0, 15)) : 4'($urandom_range(8, 15));
      endcase
      tx_idle_pct  = (p % 4 == 3) ? 0 : $urandom_range(10, 50);
      rx_stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 50);

      wait_drained();
      write_reg(REG_SCALE, {12'($urandom), s});
      write_reg(REG_NB1, pick_coef(wild, s));
      write_reg(REG_NB2, pick_coef(wild, s));
      write_reg(REG_A0,  pick_coef(wild, s));
      write_reg(REG_A1,  pick_coef(wild, s));
      write_reg(REG_A2,  pick_coef(wild, s));

      for (int k = 0; k < PHASE_LEN; k++) begin
        // Mid-phase back-pressure: sender holds until the pipe is empty.
        if (k == PHASE_LEN / 2 && p % 2 == 0) wait_drained();
        send_sample(pick_sample(), 1'b0, '0);
      end
    end

    wait_drained();

    if (mismatch_count == 0) begin
      $display("PASS biquad_iir_filter_core");
    end else begin
      $display("FAIL biquad_iir_filter_core");
    end
    $finish;
  end

endmodule
